// File: sv/lpbd_pkg.sv
`timescale 1ns / 1ps
package lpbd_pkg;
	localparam int FILE_ID_BITS = 8;
	localparam int PAGE_BITS = 20;

	localparam logic [2:0] MODE_GET = 3'd0;
	localparam logic [2:0] MODE_DIRTY = 3'd1;
	localparam logic [2:0] MODE_PROBE = 3'd2;
	localparam logic [2:0] MODE_DISCARD = 3'd3;
	localparam logic [2:0] MODE_FLUSH_PAGE = 3'd4;
	localparam logic [2:0] MODE_FLUSH_FILE = 3'd5;

	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_WRITEBACK = 2'd1;
	localparam logic [1:0] KIND_FILL = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture request, run lookup
		logic make_recent;
		logic insert;     // fill popped slot
		logic release_s;  // invalidate hit or victim slot
		logic set_dirty;
		logic clear_dirty;
		logic use_victim; // release and writeback target victim instead of hit
		logic scan_next;  // advance flush-file scan
		logic emit;       // load output register
		logic [1:0] kind;
		logic last;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] mode;
		logic hit;
		logic hit_dirty;
		logic full;
		logic victim_dirty;
		logic scan_found;
		logic scan_more;
		logic out_busy;
	} dp_status_t;
endpackage

// File: sv/lru_page_buffer_directory_top.sv
`timescale 1ns / 1ps
// channel | signals                                             | handshake
// in      | mode, file_id, page_number                          | in_valid / in_ready
// out     | kind, slot, out_file_id, out_page_number, hit,      | out_valid / out_ready
//         | dirty_flag, last                                    |
// a plain item passes the lookup register stage and the decide step; a get miss
// adds a fill step, and an evict step before it when the directory is full;
// flush page with a writeback adds a reply step, flush file a scan step per result.
// reset empties the directory at once; the free stack keeps its reset order
// through a low-water count. results wait in one output register, and a
// stalled output holds the controller before its next result.
module lru_page_buffer_directory_top #(
	parameter int NUM_PAGES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] mode,
	input logic [7:0] file_id,
	input logic [19:0] page_number,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [5:0] slot,
	output logic [7:0] out_file_id,
	output logic [19:0] out_page_number,
	output logic hit,
	output logic dirty_flag,
	output logic last
);
	lpbd_pkg::dp_cmd_t cmd;
	lpbd_pkg::dp_status_t status;

	lpbd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.status(status), .cmd(cmd)
	);

	lpbd_datapath #(
		.NUM_PAGES(NUM_PAGES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .mode(mode), .file_id(file_id),
		.page_number(page_number), .cmd(cmd), .status(status),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind), .slot(slot),
		.out_file_id(out_file_id), .out_page_number(out_page_number), .hit(hit),
		.dirty_flag(dirty_flag), .last(last)
	);
endmodule

// File: sv/lpbd_datapath.sv
`timescale 1ns / 1ps
module lpbd_datapath #(
	parameter int NUM_PAGES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic [2:0] mode,
	input logic [7:0] file_id,
	input logic [19:0] page_number,
	input lpbd_pkg::dp_cmd_t cmd,
	output lpbd_pkg::dp_status_t status,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [5:0] slot,
	output logic [7:0] out_file_id,
	output logic [19:0] out_page_number,
	output logic hit,
	output logic dirty_flag,
	output logic last
);
	localparam int SW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CW = $clog2(NUM_PAGES + 1);
	localparam int FB = lpbd_pkg::FILE_ID_BITS;
	localparam int PB = lpbd_pkg::PAGE_BITS;

	logic [FB-1:0] file_q [NUM_PAGES];
	logic [PB-1:0] page_q [NUM_PAGES];
	logic [SW-1:0] rank_q [NUM_PAGES];
	logic [NUM_PAGES-1:0] valid_q, dirty_q;
	logic [SW-1:0] stack_q [NUM_PAGES];
	logic [CW-1:0] count_q;
	logic [CW-1:0] low_q;
	logic [SW-1:0] stack_rd_q;
	logic [SW-1:0] pop_fwd_q;
	logic pop_byp_q;

	logic [2:0] mode_q;
	logic [FB-1:0] rfile_q;
	logic [PB-1:0] rpage_q;
	logic hit_q;
	logic [SW-1:0] hslot_q;
	logic [SW-1:0] victim_q;
	logic [SW-1:0] scan_q;
	logic scan_done_q;

	// lookup on the incoming request
	logic [FB-1:0] in_file;
	logic [PB-1:0] in_page;
	logic [NUM_PAGES-1:0] match;
	logic [SW-1:0] match_idx;
	logic [NUM_PAGES-1:0] lru_hit;
	logic [SW-1:0] lru_idx;
	logic [SW-1:0] max_rank;
	assign in_file = file_id[FB-1:0];
	assign in_page = page_number[PB-1:0];
	assign max_rank = SW'(NUM_PAGES - 1);

	always_comb begin
		match_idx = '0;
		lru_idx = '0;
		for (int i = 0; i < NUM_PAGES; i++) begin
			match[i] = valid_q[i] && file_q[i] == in_file && page_q[i] == in_page;
			lru_hit[i] = valid_q[i] && rank_q[i] == max_rank;
		end
		for (int i = NUM_PAGES - 1; i >= 0; i--) begin
			if (match[i]) match_idx = SW'(i);
			if (lru_hit[i]) lru_idx = SW'(i);
		end
	end

	// flush-file scan: lowest dirty slot of the file at or above the pointer
	logic [NUM_PAGES-1:0] scan_cand;
	logic [SW-1:0] scan_idx;
	logic scan_any;
	always_comb begin
		scan_idx = '0;
		scan_any = 1'b0;
		for (int i = 0; i < NUM_PAGES; i++)
			scan_cand[i] = valid_q[i] && dirty_q[i] && file_q[i] == rfile_q
				&& SW'(i) >= scan_q && !scan_done_q;
		for (int i = NUM_PAGES - 1; i >= 0; i--)
			if (scan_cand[i]) begin
				scan_idx = SW'(i);
				scan_any = 1'b1;
			end
	end
	logic [NUM_PAGES-1:0] above;
	always_comb
		for (int i = 0; i < NUM_PAGES; i++)
			above[i] = scan_cand[i] && SW'(i) != scan_idx;

	logic [SW-1:0] tgt;
	logic [SW-1:0] pop_slot;
	assign tgt = cmd.use_victim ? victim_q : hslot_q;
	assign pop_slot = pop_byp_q ? pop_fwd_q : stack_rd_q;

	assign status.mode = mode_q;
	assign status.hit = hit_q;
	assign status.hit_dirty = dirty_q[hslot_q];
	assign status.full = count_q == '0;
	assign status.victim_dirty = dirty_q[victim_q];
	assign status.scan_found = scan_any;
	assign status.scan_more = |above;
	assign status.out_busy = out_valid && !out_ready;

	logic [SW-1:0] rel_rank;
	assign rel_rank = rank_q[tgt];

	// payload of the next result
	logic [5:0] slot_d;
	logic [7:0] file_d;
	logic [19:0] page_d;
	logic hit_d;
	logic dirty_d;
	always_comb begin
		slot_d = '0;
		file_d = 8'(rfile_q);
		page_d = 20'(rpage_q);
		hit_d = 1'b0;
		dirty_d = 1'b0;
		if (cmd.kind == lpbd_pkg::KIND_FILL) begin
			slot_d = 6'(pop_slot);
		end else if (cmd.kind == lpbd_pkg::KIND_WRITEBACK) begin
			if (mode_q == lpbd_pkg::MODE_FLUSH_FILE) begin
				slot_d = 6'(scan_idx);
				file_d = 8'(file_q[scan_idx]);
				page_d = 20'(page_q[scan_idx]);
			end else begin
				slot_d = 6'(tgt);
				file_d = 8'(file_q[tgt]);
				page_d = 20'(page_q[tgt]);
			end
		end else if (mode_q == lpbd_pkg::MODE_FLUSH_FILE) begin
			page_d = '0;
		end else if (hit_q && mode_q <= lpbd_pkg::MODE_FLUSH_PAGE) begin
			slot_d = 6'(hslot_q);
			hit_d = 1'b1;
			dirty_d = (mode_q == lpbd_pkg::MODE_DISCARD) ? 1'b0 :
				(mode_q == lpbd_pkg::MODE_FLUSH_PAGE) ? 1'b0 :
				(mode_q == lpbd_pkg::MODE_DIRTY) ? 1'b1 : dirty_q[hslot_q];
		end
	end

	// free stack, top entry read into a register ahead of the pop
	always_ff @(posedge clk) begin
		if (cmd.release_s) stack_q[SW'(count_q)] <= tgt;
		stack_rd_q <= stack_q[SW'(count_q - CW'(1))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			count_q <= CW'(NUM_PAGES);
			low_q <= CW'(NUM_PAGES);
			pop_fwd_q <= '0;
			pop_byp_q <= 1'b0;
			out_valid <= 1'b0;
			scan_q <= '0;
			scan_done_q <= 1'b0;
		end else begin
			// a slot just pushed is forwarded; entries below the lowest count
			// reached still hold their reset order
			if (cmd.release_s) begin
				pop_byp_q <= 1'b1;
				pop_fwd_q <= tgt;
			end else if (count_q == low_q) begin
				pop_byp_q <= 1'b1;
				pop_fwd_q <= SW'(CW'(NUM_PAGES) - count_q);
			end else
				pop_byp_q <= 1'b0;
			if (cmd.load) begin
				mode_q <= mode;
				rfile_q <= in_file;
				rpage_q <= in_page;
				hit_q <= |match;
				hslot_q <= match_idx;
				victim_q <= lru_idx;
				scan_q <= '0;
				scan_done_q <= 1'b0;
			end
			if (cmd.scan_next) begin
				dirty_q[scan_idx] <= 1'b0;
				if (scan_idx == max_rank) scan_done_q <= 1'b1;
				else scan_q <= scan_idx + SW'(1);
			end
			if (cmd.set_dirty) dirty_q[hslot_q] <= 1'b1;
			if (cmd.clear_dirty) dirty_q[tgt] <= 1'b0;
			if (cmd.make_recent) begin
				for (int i = 0; i < NUM_PAGES; i++)
					if (valid_q[i] && rank_q[i] < rank_q[hslot_q]) rank_q[i] <= rank_q[i] + SW'(1);
				rank_q[hslot_q] <= '0;
			end
			if (cmd.release_s) begin
				for (int i = 0; i < NUM_PAGES; i++)
					if (valid_q[i] && rank_q[i] > rel_rank) rank_q[i] <= rank_q[i] - SW'(1);
				valid_q[tgt] <= 1'b0;
				dirty_q[tgt] <= 1'b0;
				count_q <= count_q + CW'(1);
			end
			if (cmd.insert) begin
				for (int i = 0; i < NUM_PAGES; i++)
					if (valid_q[i]) rank_q[i] <= rank_q[i] + SW'(1);
				valid_q[pop_slot] <= 1'b1;
				dirty_q[pop_slot] <= 1'b0;
				file_q[pop_slot] <= rfile_q;
				page_q[pop_slot] <= rpage_q;
				rank_q[pop_slot] <= '0;
				count_q <= count_q - CW'(1);
				if (count_q == low_q) low_q <= count_q - CW'(1);
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
				kind <= cmd.kind;
				last <= cmd.last;
				hit <= hit_d;
				dirty_flag <= dirty_d;
				out_file_id <= file_d;
				out_page_number <= page_d;
				slot <= slot_d;
			end else if (out_valid && out_ready)
				out_valid <= 1'b0;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_PAGES)) else $error("free count overflow");
	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> count_q != '0) else $error("insert with empty free stack");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && !out_ready)) else $error("result overwritten");
endmodule

// File: sv/lpbd_ctrl.sv
`timescale 1ns / 1ps
module lpbd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lpbd_pkg::dp_status_t status,
	output lpbd_pkg::dp_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_EVICT, S_FILL, S_SCAN, S_FLUSH_REPLY
	} state_t;
	state_t state_q;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && state_q == S_IDLE;
		if (!status.out_busy) begin
			case (state_q)
				S_DECIDE: begin
					case (status.mode)
						lpbd_pkg::MODE_GET: begin
							if (status.hit) begin
								cmd.make_recent = 1'b1;
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
							end else if (status.full && status.victim_dirty) begin
								cmd.emit = 1'b1;
								cmd.kind = lpbd_pkg::KIND_WRITEBACK;
								cmd.use_victim = 1'b1;
							end
						end
						lpbd_pkg::MODE_FLUSH_FILE: ;
						lpbd_pkg::MODE_DIRTY, lpbd_pkg::MODE_PROBE, lpbd_pkg::MODE_DISCARD: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							cmd.set_dirty = status.hit && status.mode == lpbd_pkg::MODE_DIRTY;
							cmd.release_s = status.hit && status.mode == lpbd_pkg::MODE_DISCARD;
						end
						lpbd_pkg::MODE_FLUSH_PAGE: begin
							cmd.emit = 1'b1;
							if (status.hit && status.hit_dirty) begin
								cmd.kind = lpbd_pkg::KIND_WRITEBACK;
								cmd.clear_dirty = 1'b1;
							end else
								cmd.last = 1'b1;
						end
						default: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
						end
					endcase
				end
				S_FILL: begin
					cmd.insert = 1'b1;
					cmd.emit = 1'b1;
					cmd.kind = lpbd_pkg::KIND_FILL;
					cmd.last = 1'b1;
				end
				S_SCAN: begin
					cmd.emit = 1'b1;
					if (status.scan_found) begin
						cmd.kind = lpbd_pkg::KIND_WRITEBACK;
						cmd.scan_next = 1'b1;
						cmd.last = !status.scan_more;
					end else
						cmd.last = 1'b1;
				end
				S_FLUSH_REPLY: begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
				end
				default: ;
			endcase
		end
		// eviction needs no output slot
		if (state_q == S_EVICT) begin
			cmd.use_victim = 1'b1;
			cmd.release_s = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (status.mode == lpbd_pkg::MODE_FLUSH_FILE)
						state_q <= S_SCAN;
					else if (!status.out_busy) begin
						if (status.mode == lpbd_pkg::MODE_GET && !status.hit)
							state_q <= status.full ? S_EVICT : S_FILL;
						else if (status.mode == lpbd_pkg::MODE_FLUSH_PAGE && status.hit
							&& status.hit_dirty)
							state_q <= S_FLUSH_REPLY;
						else
							state_q <= S_IDLE;
					end
				end
				S_EVICT: state_q <= S_FILL;
				S_FILL, S_FLUSH_REPLY: if (!status.out_busy) state_q <= S_IDLE;
				S_SCAN: if (!status.out_busy && (!status.scan_found || !status.scan_more))
					state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.insert, cmd.release_s, cmd.make_recent})) else $error("conflicting updates");
	a_evict_then_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVICT |=> state_q == S_FILL) else $error("eviction not followed by fill");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE) else $error("load outside idle");
endmodule
